// ----- hw/rtl/unanimous_vote_with_timeout_defines.svh -----
// Assertion helpers shared by the vote logic.
`ifndef UNANIMOUS_VOTE_WITH_TIMEOUT_DEFINES_SVH
`define UNANIMOUS_VOTE_WITH_TIMEOUT_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define UVWT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uvwt: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define UVWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uvwt: next-cycle check failed");

`endif

// ----- hw/rtl/uvwt_pkg.sv -----
`timescale 1ns / 1ps

package uvwt_pkg;

   localparam int unsigned PLAYERS_DEFAULT = 4;
   localparam logic [30:0] TIMEOUT_RESET = 31'd30000;
   localparam logic [30:0] MAX31         = 31'h7FFF_FFFF;

   // event kinds
   localparam logic [2:0] KIND_REQUEST = 3'd0;
   localparam logic [2:0] KIND_RESPOND = 3'd1;
   localparam logic [2:0] KIND_TICK    = 3'd2;
   localparam logic [2:0] KIND_COMMIT  = 3'd3;
   localparam logic [2:0] KIND_RESTART = 3'd4;
   localparam logic [2:0] KIND_CLEAR   = 3'd5;

   // vote phases
   localparam logic [2:0] PHASE_IDLE       = 3'd0;
   localparam logic [2:0] PHASE_WAITING    = 3'd1;
   localparam logic [2:0] PHASE_READY      = 3'd2;
   localparam logic [2:0] PHASE_CANCELLED  = 3'd3;
   localparam logic [2:0] PHASE_COMMITTING = 3'd4;

   // result codes
   localparam logic [3:0] CODE_OPENED    = 4'd0;
   localparam logic [3:0] CODE_READY     = 4'd1;
   localparam logic [3:0] CODE_NOCHANGE  = 4'd2;
   localparam logic [3:0] CODE_CANCELLED = 4'd3;
   localparam logic [3:0] CODE_COMMIT    = 4'd4;
   localparam logic [3:0] CODE_RESTARTED = 4'd5;
   localparam logic [3:0] CODE_INVALID   = 4'd6;
   localparam logic [3:0] CODE_BUSY      = 4'd7;
   localparam logic [3:0] CODE_STALE     = 4'd8;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  seat;
      logic [7:0]  active_mask;
      logic [31:0] now_ms;
      logic [31:0] vote_serial;
      logic        accept;
   } vote_event_type;

   typedef struct packed {
      logic [3:0]  code;
      logic [2:0]  phase;
      logic [31:0] current_serial;
      logic [7:0]  participants;
      logic [7:0]  accepted;
      logic [7:0]  cancelled_by;
      logic [30:0] remaining_ms;
   } vote_result_type;

endpackage

// ----- hw/rtl/unanimous_vote_with_timeout.sv -----
`timescale 1ns / 1ps
// Path: a request transfer loads the input register (evt_ff), and the result register
//   (result_ff) loads when that event fires, which waits while rsp_ready holds it off.
// Throughput: one event per cycle unless rsp_ready stalls the output; the vote state closes its loop within each event.
// Reset: synchronous, active high; clears the vote state, the serial and the valid
//   flags of both register stages, and sets the timeout to 30000 ms.
module unanimous_vote_with_timeout #(
   parameter int unsigned PLAYERS = uvwt_pkg::PLAYERS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [3:0]  req_seat,
   input  logic [7:0]  req_active_mask,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_vote_serial,
   input  logic        req_accept,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_code,
   output logic [2:0]  rsp_phase,
   output logic [31:0] rsp_current_serial,
   output logic [7:0]  rsp_participants,
   output logic [7:0]  rsp_accepted,
   output logic [7:0]  rsp_cancelled_by,
   output logic [30:0] rsp_remaining_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_vote_timeout
);
   import uvwt_pkg::*;

   logic            in_valid_ff, in_valid_in;
   vote_event_type  evt_ff;
   logic            out_valid_ff, out_valid_in;
   vote_result_type result_ff;
   vote_result_type result;
   logic [30:0]     timeout_ff;
   logic            fire;
   logic            req_xfer;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_vote_timeout;
         end
      end
   end

   // hold payloads until the next transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         evt_ff.kind        <= req_kind;
         evt_ff.seat        <= req_seat;
         evt_ff.active_mask <= req_active_mask;
         evt_ff.now_ms      <= req_now_ms;
         evt_ff.vote_serial <= req_vote_serial;
         evt_ff.accept      <= req_accept;
      end
      if (fire) begin
         result_ff <= result;
      end
   end

   uvwt_core #(
      .PLAYERS(PLAYERS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .evt         (evt_ff),
      .vote_timeout(timeout_ff),
      .result      (result)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_code           = result_ff.code;
   assign rsp_phase          = result_ff.phase;
   assign rsp_current_serial = result_ff.current_serial;
   assign rsp_participants   = result_ff.participants;
   assign rsp_accepted       = result_ff.accepted;
   assign rsp_cancelled_by   = result_ff.cancelled_by;
   assign rsp_remaining_ms   = result_ff.remaining_ms;

endmodule

// ----- hw/rtl/uvwt_core.sv -----
`timescale 1ns / 1ps
`include "unanimous_vote_with_timeout_defines.svh"

module uvwt_core #(
   parameter int unsigned PLAYERS = uvwt_pkg::PLAYERS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  uvwt_pkg::vote_event_type evt,
   input  logic [30:0]              vote_timeout,
   output uvwt_pkg::vote_result_type result
);
   import uvwt_pkg::*;

   localparam logic [7:0] PlayerMask  = 8'((9'd1 << PLAYERS) - 9'd1);
   localparam logic [3:0] PlayerCount = 4'(PLAYERS);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] serial_ff, serial_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [2:0]  requester_ff, requester_in;
   logic [7:0]  part_ff, part_in;
   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  cancel_ff, cancel_in;

   logic [7:0]  act;
   logic [7:0]  idx_bit;
   logic [7:0]  req_bit;
   logic        serial_ok;
   logic        timeout_zero;
   logic        fresh_deadline;
   logic [31:0] elapsed;
   logic [31:0] rem_raw;
   logic        reached;
   logic [3:0]  code;
   logic [30:0] rem;

   assign act          = evt.active_mask & PlayerMask;
   assign idx_bit      = (evt.seat < PlayerCount) ?
                         (8'd1 << evt.seat[2:0]) : 8'd0;
   assign req_bit      = 8'd1 << requester_ff;
   assign serial_ok    = (evt.vote_serial != 32'd0) && (evt.vote_serial == serial_ff);
   assign timeout_zero = (vote_timeout == 31'd0);
   assign elapsed      = evt.now_ms - deadline_ff;
   assign rem_raw      = deadline_ff - evt.now_ms;
   assign reached      = !elapsed[31];

   always_comb begin
      phase_in       = phase_ff;
      serial_in      = serial_ff;
      deadline_in    = deadline_ff;
      requester_in   = requester_ff;
      part_in        = part_ff;
      acc_in         = acc_ff;
      cancel_in      = cancel_ff;
      code           = CODE_INVALID;
      fresh_deadline = 1'b0;
      case (evt.kind)
         KIND_REQUEST: begin
            if (timeout_zero) begin
               code = CODE_INVALID;
            end else if (phase_ff != PHASE_IDLE) begin
               code = CODE_BUSY;
            end else if (idx_bit == 8'd0 || (act & idx_bit) == 8'd0) begin
               code = CODE_INVALID;
            end else begin
               // serial skips zero on wrap
               serial_in      = (serial_ff == '1) ? 32'd1 : serial_ff + 32'd1;
               deadline_in    = evt.now_ms + {1'b0, vote_timeout};
               requester_in   = evt.seat[2:0];
               part_in        = act;
               acc_in         = idx_bit;
               cancel_in      = 8'd0;
               fresh_deadline = 1'b1;
               if ((act & ~idx_bit) == 8'd0) begin
                  phase_in = PHASE_READY;
                  code     = CODE_READY;
               end else begin
                  phase_in = PHASE_WAITING;
                  code     = CODE_OPENED;
               end
            end
         end
         KIND_RESPOND: begin
            if (!serial_ok) begin
               code = CODE_STALE;
            end else if (phase_ff != PHASE_WAITING) begin
               code = CODE_BUSY;
            end else if (idx_bit == 8'd0 || (part_ff & idx_bit) == 8'd0) begin
               code = CODE_INVALID;
            end else if (!evt.accept) begin
               cancel_in = idx_bit;
               phase_in  = PHASE_CANCELLED;
               code      = CODE_CANCELLED;
            end else begin
               acc_in = acc_ff | idx_bit;
               if ((acc_in & part_ff) == part_ff) begin
                  phase_in = PHASE_READY;
                  code     = CODE_READY;
               end else begin
                  code = CODE_NOCHANGE;
               end
            end
         end
         KIND_TICK: begin
            if (phase_ff != PHASE_WAITING) begin
               code = CODE_NOCHANGE;
            end else if ((act & req_bit) == 8'd0) begin
               // requester has left
               cancel_in = req_bit;
               phase_in  = PHASE_CANCELLED;
               code      = CODE_CANCELLED;
            end else begin
               part_in = part_ff & act;
               acc_in  = acc_ff & part_in;
               if ((acc_in & part_in) == part_in || reached) begin
                  phase_in = PHASE_READY;
                  code     = CODE_READY;
               end else begin
                  code = CODE_NOCHANGE;
               end
            end
         end
         KIND_COMMIT: begin
            if (!serial_ok) begin
               code = CODE_STALE;
            end else if (phase_ff != PHASE_READY) begin
               code = CODE_BUSY;
            end else begin
               phase_in = PHASE_COMMITTING;
               code     = CODE_COMMIT;
            end
         end
         KIND_RESTART: begin
            if (!serial_ok || phase_ff != PHASE_WAITING || timeout_zero) begin
               code = CODE_INVALID;
            end else begin
               deadline_in    = evt.now_ms + {1'b0, vote_timeout};
               fresh_deadline = 1'b1;
               code           = CODE_RESTARTED;
            end
         end
         KIND_CLEAR: begin
            phase_in     = PHASE_IDLE;
            deadline_in  = 32'd0;
            requester_in = 3'd0;
            part_in      = 8'd0;
            acc_in       = 8'd0;
            cancel_in    = 8'd0;
            code         = CODE_NOCHANGE;
         end
         default: begin
            code = CODE_INVALID;
         end
      endcase
   end

   // A freshly set deadline is exactly one timeout away, so skip the subtract.
   always_comb begin
      rem = 31'd0;
      if (phase_in == PHASE_WAITING) begin
         if (fresh_deadline) begin
            rem = vote_timeout;
         end else if (!reached) begin
            rem = rem_raw[31] ? MAX31 : rem_raw[30:0];
         end
      end
   end

   assign result.code           = code;
   assign result.phase          = phase_in;
   assign result.current_serial = serial_in;
   assign result.participants   = part_in;
   assign result.accepted       = acc_in;
   assign result.cancelled_by   = cancel_in;
   assign result.remaining_ms   = rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         serial_ff    <= 32'd0;
         deadline_ff  <= 32'd0;
         requester_ff <= 3'd0;
         part_ff      <= 8'd0;
         acc_ff       <= 8'd0;
         cancel_ff    <= 8'd0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         serial_ff    <= serial_in;
         deadline_ff  <= deadline_in;
         requester_ff <= requester_in;
         part_ff      <= part_in;
         acc_ff       <= acc_in;
         cancel_ff    <= cancel_in;
      end
   end

   `UVWT_ASSERT_NOW(a_serial_live, clock, reset, phase_ff != PHASE_IDLE, serial_ff != 32'd0)
   `UVWT_ASSERT_NOW(a_acc_subset, clock, reset, phase_ff == PHASE_WAITING, (acc_ff & ~part_ff) == 8'd0)
   `UVWT_ASSERT_NOW(a_cancel_phase, clock, reset, cancel_ff != 8'd0, $onehot0(cancel_ff) && phase_ff == PHASE_CANCELLED)
   `UVWT_ASSERT_NEXT(a_open_waits, clock, reset, fire && code == CODE_OPENED, phase_ff == PHASE_WAITING)

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import uvwt_pkg::*;

   localparam int unsigned PLAYERS = PLAYERS_DEFAULT;
   localparam logic [7:0] PLAYER_MASK = 8'((1 << PLAYERS) - 1);

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_kind;
   logic [3:0]  req_seat;
   logic [7:0]  req_active_mask;
   logic [31:0] req_now_ms;
   logic [31:0] req_vote_serial;
   logic        req_accept;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_code;
   logic [2:0]  rsp_phase;
   logic [31:0] rsp_current_serial;
   logic [7:0]  rsp_participants;
   logic [7:0]  rsp_accepted;
   logic [7:0]  rsp_cancelled_by;
   logic [30:0] rsp_remaining_ms;
   logic        csr_valid;
   logic        csr_ready;
   logic [30:0] csr_vote_timeout;

   unanimous_vote_with_timeout #(
      .PLAYERS(PLAYERS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_seat           (req_seat),
      .req_active_mask    (req_active_mask),
      .req_now_ms         (req_now_ms),
      .req_vote_serial    (req_vote_serial),
      .req_accept         (req_accept),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code           (rsp_code),
      .rsp_phase          (rsp_phase),
      .rsp_current_serial (rsp_current_serial),
      .rsp_participants   (rsp_participants),
      .rsp_accepted       (rsp_accepted),
      .rsp_cancelled_by   (rsp_cancelled_by),
      .rsp_remaining_ms   (rsp_remaining_ms),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_vote_timeout   (csr_vote_timeout)
   );

   // vote state as the block should hold it
   logic [30:0] vote_limit;
   logic [2:0]  ballot_phase;
   logic [31:0] ballot_serial;
   logic [31:0] ballot_deadline;
   logic [2:0]  ballot_owner;
   logic [7:0]  voter_bits;
   logic [7:0]  yes_bits;
   logic [7:0]  veto_bits;

   vote_result_type predicted_tallies[$];
   logic [31:0] wall_ms;
   int items_sent;
   int mismatches;
   int settings_written;
   int code_seen[16];
   int hold_off_request;
   bit sender_calm;
   bit burst_mode;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] member_bit(input logic [3:0] idx);
      if (idx >= PLAYERS) return 8'h00;
      return 8'(1 << idx);
   endfunction

   function automatic bit past_deadline(input logic [31:0] now);
      logic [31:0] diff;
      diff = now - ballot_deadline;
      return !diff[31];
   endfunction

   function automatic bit serial_matches(input logic [31:0] serial);
      return serial != 32'd0 && serial == ballot_serial;
   endfunction

   function automatic void clear_ballot();
      ballot_phase = PHASE_IDLE;
      ballot_deadline = '0;
      ballot_owner = '0;
      voter_bits = '0;
      yes_bits = '0;
      veto_bits = '0;
   endfunction

   // Apply one event to the vote state and return what the block must answer.
   function automatic vote_result_type tally_vote(input vote_event_type ev);
      vote_result_type r;
      logic [7:0]  who;
      logic [7:0]  act;
      logic [31:0] time_left;
      r = '0;
      r.code = CODE_INVALID;
      act = ev.active_mask & PLAYER_MASK;
      who = member_bit(ev.seat);
      case (ev.kind)
         KIND_REQUEST: begin
            if (vote_limit == 0) begin
               r.code = CODE_INVALID;
            end else if (ballot_phase != PHASE_IDLE) begin
               r.code = CODE_BUSY;
            end else if (who == 0 || (act & who) == 0) begin
               r.code = CODE_INVALID;
            end else begin
               ballot_serial = ballot_serial + 32'd1;
               if (ballot_serial == 0) ballot_serial = 32'd1;
               ballot_deadline = ev.now_ms + 32'(vote_limit);
               ballot_owner = ev.seat[2:0];
               voter_bits = act;
               yes_bits = who;
               veto_bits = '0;
               if ((act & ~who) == 0) begin
                  ballot_phase = PHASE_READY;
                  r.code = CODE_READY;
               end else begin
                  ballot_phase = PHASE_WAITING;
                  r.code = CODE_OPENED;
               end
            end
         end
         KIND_RESPOND: begin
            if (!serial_matches(ev.vote_serial)) begin
               r.code = CODE_STALE;
            end else if (ballot_phase != PHASE_WAITING) begin
               r.code = CODE_BUSY;
            end else if (who == 0 || (voter_bits & who) == 0) begin
               r.code = CODE_INVALID;
            end else if (!ev.accept) begin
               veto_bits = who;
               ballot_phase = PHASE_CANCELLED;
               r.code = CODE_CANCELLED;
            end else begin
               yes_bits = yes_bits | who;
               if ((yes_bits & voter_bits) == voter_bits) begin
                  ballot_phase = PHASE_READY;
                  r.code = CODE_READY;
               end else begin
                  r.code = CODE_NOCHANGE;
               end
            end
         end
         KIND_TICK: begin
            if (ballot_phase != PHASE_WAITING) begin
               r.code = CODE_NOCHANGE;
            end else if ((act & member_bit({1'b0, ballot_owner})) == 0) begin
               // requester has left
               veto_bits = member_bit({1'b0, ballot_owner});
               ballot_phase = PHASE_CANCELLED;
               r.code = CODE_CANCELLED;
            end else begin
               voter_bits = voter_bits & act;
               yes_bits = yes_bits & voter_bits;
               if ((yes_bits & voter_bits) == voter_bits || past_deadline(ev.now_ms)) begin
                  ballot_phase = PHASE_READY;
                  r.code = CODE_READY;
               end else begin
                  r.code = CODE_NOCHANGE;
               end
            end
         end
         KIND_COMMIT: begin
            if (!serial_matches(ev.vote_serial)) begin
               r.code = CODE_STALE;
            end else if (ballot_phase != PHASE_READY) begin
               r.code = CODE_BUSY;
            end else begin
               ballot_phase = PHASE_COMMITTING;
               r.code = CODE_COMMIT;
            end
         end
         KIND_RESTART: begin
            if (!serial_matches(ev.vote_serial) || ballot_phase != PHASE_WAITING ||
                vote_limit == 0) begin
               r.code = CODE_INVALID;
            end else begin
               ballot_deadline = ev.now_ms + 32'(vote_limit);
               r.code = CODE_RESTARTED;
            end
         end
         KIND_CLEAR: begin
            clear_ballot();
            r.code = CODE_NOCHANGE;
         end
         default: begin
            r.code = CODE_INVALID;
         end
      endcase
      if (ballot_phase == PHASE_WAITING && !past_deadline(ev.now_ms)) begin
         time_left = ballot_deadline - ev.now_ms;
         r.remaining_ms = (time_left > 32'(MAX31)) ? MAX31 : time_left[30:0];
      end
      r.phase = ballot_phase;
      r.current_serial = ballot_serial;
      r.participants = voter_bits;
      r.accepted = yes_bits;
      r.cancelled_by = veto_bits;
      return r;
   endfunction

   function automatic vote_event_type make_event(input logic [2:0] kind,
                                                 input logic [3:0] who,
                                                 input logic [7:0] mask,
                                                 input logic [31:0] now,
                                                 input logic [31:0] serial,
                                                 input logic accept);
      vote_event_type ev;
      ev.kind = kind;
      ev.seat = who;
      ev.active_mask = mask;
      ev.now_ms = now;
      ev.vote_serial = serial;
      ev.accept = accept;
      return ev;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Advance the wall clock; often land right around the deadline.
   function automatic logic [31:0] next_now();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) wall_ms = wall_ms + $urandom_range(0, vote_limit / 4 + 1);
      else if (r < 85) wall_ms = ballot_deadline + $urandom_range(0, 4) - 32'd2;
      else if (r < 95) wall_ms = wall_ms + $urandom_range(0, vote_limit + 3);
      else wall_ms = $urandom;
      return wall_ms;
   endfunction

   function automatic logic [3:0] pick_voter();
      logic [7:0] undecided;
      int first;
      int k;
      int n;
      undecided = voter_bits & ~yes_bits;
      if (undecided == 0 || $urandom_range(0, 9) == 0)
         return 4'($urandom_range(0, PLAYERS - 1));
      first = $urandom_range(0, 7);
      for (k = 0; k < 8; k++) begin
         n = (first + k) % 8;
         if (undecided[n]) return 4'(n);
      end
      return 4'd0;
   endfunction

   function automatic vote_event_type noise_event();
      logic [31:0] serial;
      logic [31:0] now;
      case ($urandom_range(0, 4))
         0: serial = 32'd0;
         1: serial = ballot_serial;
         2: serial = ballot_serial + 32'd1;
         3: serial = ballot_serial - 32'd1;
         default: serial = $urandom;
      endcase
      now = ($urandom_range(0, 3) == 0) ? 32'($urandom) : next_now();
      return make_event(3'($urandom_range(0, 5)), 4'($urandom), 8'($urandom), now, serial,
                        1'($urandom));
   endfunction

   function automatic vote_event_type vote_step_event();
      int unsigned r;
      logic [7:0] mask;
      r = $urandom_range(0, 99);
      mask = voter_bits | (8'($urandom) & ~PLAYER_MASK);
      if (r < 45)
         return make_event(KIND_RESPOND, pick_voter(), 8'($urandom), next_now(), ballot_serial,
                           $urandom_range(0, 11) != 0);
      if (r < 70) begin
         if ($urandom_range(0, 4) == 0)
            mask = mask & ~member_bit(4'($urandom_range(0, PLAYERS - 1)));
         return make_event(KIND_TICK, 4'($urandom), mask, next_now(), $urandom, 1'($urandom));
      end
      if (r < 80)
         return make_event(KIND_RESTART, 4'($urandom), 8'($urandom), next_now(), ballot_serial,
                           1'($urandom));
      return noise_event();
   endfunction

   // Offer one event and wait for its transfer; the prediction is made on acceptance.
   task automatic send_event(input vote_event_type ev);
      int gap;
      if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
      gap = (burst_mode || sender_calm) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_kind, req_seat, req_active_mask, req_now_ms, req_vote_serial, req_accept} <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted_tallies.push_back(tally_vote(ev));
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_tallies.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [30:0] value);
      csr_valid <= 1'b1;
      csr_vote_timeout <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      vote_limit = value;
      settings_written++;
   endtask

   // One vote from opening to commit once it is ready, with noise mixed in.
   task automatic run_vote_round();
      int steps;
      logic [3:0] owner;
      logic [7:0] mask;
      if ($urandom_range(0, 9) == 0) send_event(noise_event());
      if (ballot_phase != PHASE_IDLE && $urandom_range(0, 6) != 0)
         send_event(make_event(KIND_CLEAR, 4'($urandom), 8'($urandom), next_now(), $urandom,
                               1'($urandom)));
      owner = 4'($urandom_range(0, PLAYERS - 1));
      mask = 8'($urandom) | member_bit(owner);
      if ($urandom_range(0, 9) == 0) mask = member_bit(owner) | (8'($urandom) & ~PLAYER_MASK);
      send_event(make_event(KIND_REQUEST, owner, mask, next_now(), $urandom, 1'($urandom)));
      steps = $urandom_range(1, 10);
      while (ballot_phase == PHASE_WAITING && steps > 0) begin
         send_event(vote_step_event());
         steps--;
      end
      if (ballot_phase == PHASE_READY) begin
         if ($urandom_range(0, 9) == 0)
            send_event(make_event(KIND_COMMIT, 4'($urandom), 8'($urandom), next_now(),
                                  ballot_serial + 32'd1, 1'($urandom)));
         send_event(make_event(KIND_COMMIT, 4'($urandom), 8'($urandom), next_now(),
                               ballot_serial, 1'($urandom)));
      end
   endtask

   task automatic test_directed_cases();
      send_event(make_event(KIND_RESPOND, 4'd0, 8'h0F, 32'd10, 32'd0, 1'b1));
      send_event(make_event(KIND_REQUEST, 4'd9, 8'hFF, 32'd20, 32'd0, 1'b0));
      send_event(make_event(KIND_REQUEST, 4'd2, 8'h03, 32'd30, 32'd0, 1'b0));
      // requester alone among present members: ready at once
      send_event(make_event(KIND_REQUEST, 4'd1, 8'hF2, 32'd40, 32'hFFFF_FFFF, 1'b1));
      send_event(make_event(KIND_REQUEST, 4'd0, 8'h0F, 32'd50, 32'd0, 1'b0));
      send_event(make_event(KIND_RESPOND, 4'd1, 8'h0F, 32'd60, ballot_serial, 1'b1));
      send_event(make_event(KIND_COMMIT, 4'd0, 8'h00, 32'd70, ballot_serial + 32'd1, 1'b0));
      send_event(make_event(KIND_RESTART, 4'd0, 8'h00, 32'd75, ballot_serial, 1'b1));
      send_event(make_event(KIND_COMMIT, 4'd0, 8'h00, 32'd80, ballot_serial, 1'b0));
      send_event(make_event(KIND_TICK, 4'd15, 8'hFF, 32'd90, 32'd0, 1'b1));
      send_event(make_event(KIND_CLEAR, 4'd15, 8'hFF, 32'd95, 32'hFFFF_FFFF, 1'b1));
      send_event(make_event(KIND_REQUEST, 4'd0, 8'h0F, 32'd1000, 32'd0, 1'b0));
      send_event(make_event(KIND_RESPOND, 4'd7, 8'h0F, 32'd1100, ballot_serial, 1'b1));
      send_event(make_event(KIND_RESPOND, 4'd1, 8'h0F, 32'd1200, ballot_serial, 1'b1));
      send_event(make_event(KIND_RESTART, 4'd0, 8'h0F, 32'd1300, ballot_serial + 32'd5, 1'b0));
      send_event(make_event(KIND_RESTART, 4'd0, 8'h0F, 32'd5000, ballot_serial, 1'b0));
      // member 2 leaves; member 3 still owes an answer
      send_event(make_event(KIND_TICK, 4'd0, 8'hFB, 32'd6000, 32'd0, 1'b0));
      send_event(make_event(KIND_RESPOND, 4'd3, 8'h0F, 32'd6100, ballot_serial, 1'b1));
      send_event(make_event(KIND_CLEAR, 4'd0, 8'h00, 32'd6200, 32'd0, 1'b0));
      // deadline wraps past the top of the counter
      send_event(make_event(KIND_REQUEST, 4'd2, 8'h0F, 32'hFFFF_FF00, 32'd0, 1'b0));
      send_event(make_event(KIND_TICK, 4'd0, 8'h0F, ballot_deadline - 32'h8000_0000, 32'd0,
                            1'b0));
      send_event(make_event(KIND_TICK, 4'd0, 8'h0F, ballot_deadline, 32'd0, 1'b0));
      send_event(make_event(KIND_CLEAR, 4'd0, 8'h00, 32'd0, 32'd0, 1'b0));
      send_event(make_event(KIND_REQUEST, 4'd3, 8'h0C, 32'd100, 32'd0, 1'b0));
      send_event(make_event(KIND_RESPOND, 4'd2, 8'h0C, 32'd110, ballot_serial, 1'b0));
      send_event(make_event(KIND_CLEAR, 4'd0, 8'h00, 32'd120, 32'd0, 1'b0));
      send_event(make_event(KIND_REQUEST, 4'd0, 8'h03, 32'd130, 32'd0, 1'b0));
      send_event(make_event(KIND_TICK, 4'd0, 8'h02, 32'd140, 32'd0, 1'b0));
   endtask

   task automatic test_timeout_sweep();
      logic [30:0] settings[7];
      int goal;
      int n;
      settings[0] = 31'd1;
      settings[1] = MAX31;
      settings[2] = 31'd2;
      settings[3] = 31'($urandom_range(3, 100));
      settings[4] = 31'($urandom_range(1000, 100000));
      settings[5] = 31'($urandom_range(1, MAX31));
      settings[6] = TIMEOUT_RESET;
      for (n = 0; n < 7; n++) begin
         wait_for_results();
         write_timeout(settings[n]);
         goal = items_sent + 240;
         while (items_sent < goal) run_vote_round();
      end
   endtask

   // Hold the result side off while events keep coming, so the input stalls.
   task automatic test_receiver_hold_off();
      int goal;
      wait_for_results();
      hold_off_request = 200;
      burst_mode = 1'b1;
      goal = items_sent + 60;
      while (items_sent < goal) run_vote_round();
      burst_mode = 1'b0;
   endtask

   initial begin : result_sink
      int stall_left;
      bit calm;
      stall_left = 0;
      calm = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            stall_left = hold_off_request;
            hold_off_request = 0;
         end
         if ($urandom_range(0, 79) == 0) calm = !calm;
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      vote_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_tallies.size() == 0) begin
            $error("result transfer with no event outstanding (code %0d)", rsp_code);
            mismatches++;
         end else begin
            want = predicted_tallies.pop_front();
            code_seen[want.code]++;
            compare_field("code", want.code, rsp_code);
            compare_field("phase", want.phase, rsp_phase);
            compare_field("current_serial", want.current_serial, rsp_current_serial);
            compare_field("participants", want.participants, rsp_participants);
            compare_field("accepted", want.accepted, rsp_accepted);
            compare_field("cancelled_by", want.cancelled_by, rsp_cancelled_by);
            compare_field("remaining_ms", want.remaining_ms, rsp_remaining_ms);
         end
      end
   end

   initial begin
      #15_000_000;
      $display("run timed out with %0d results outstanding", predicted_tallies.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      {req_kind, req_seat, req_active_mask, req_now_ms, req_vote_serial, req_accept} <= '0;
      csr_valid <= 1'b0;
      csr_vote_timeout <= '0;
      vote_limit = TIMEOUT_RESET;
      ballot_serial = '0;
      clear_ballot();
      wall_ms = '0;
      items_sent = 0;
      mismatches = 0;
      settings_written = 0;
      hold_off_request = 0;
      sender_calm = 1'b0;
      burst_mode = 1'b0;
      foreach (code_seen[i]) code_seen[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_timeout_sweep();
      test_receiver_hold_off();

      wait_for_results();
      repeat (8) @(posedge clock);
      $display("%0d events over %0d timeout settings, last serial %0d", items_sent,
               settings_written, ballot_serial);
      $display("opened %0d ready %0d no-change %0d cancelled %0d commit %0d restarted %0d",
               code_seen[CODE_OPENED], code_seen[CODE_READY], code_seen[CODE_NOCHANGE],
               code_seen[CODE_CANCELLED], code_seen[CODE_COMMIT], code_seen[CODE_RESTARTED]);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
